[hw/rtl/iwpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwpc_pkg
// Shared types and constants of the indexed wheel position controller: beat
// layouts, event and outcome codes, configuration register map and flags.
// ----------------------------------------------------------------------------
package iwpc_pkg;

    // Field widths fixed by the beat layout
    localparam int STORED_W      = 6;
    localparam int POS_BITS_MAX  = 7;
    localparam int HSPR_W        = 16;
    localparam int CODE_W        = 8;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    // Register reset values
    localparam logic [HSPR_W-1:0] HSPR_RESET      = 16'd4096;
    localparam logic [CODE_W-1:0] KEEP_RESET      = 8'd0;
    localparam logic [CODE_W-1:0] HOME_RESET      = 8'd1;
    localparam logic [CODE_W-1:0] FIRST_POS_RESET = 8'd64;

    // Event codes
    typedef enum logic [2:0] {
        CMD_LOAD      = 3'd0,
        CMD_HOST      = 3'd1,
        CMD_STEP      = 3'd2,
        CMD_SENSOR    = 3'd3,
        CMD_HOME_FAIL = 3'd4,
        CMD_PERSISTED = 3'd5,
        CMD_QUERY     = 3'd6
    } cmd_e;

    // Host command outcome codes
    typedef enum logic [1:0] {
        OUT_ACCEPTED   = 2'd0,
        OUT_IGNORED    = 2'd1,
        OUT_START_HOME = 2'd2,
        OUT_START_MOVE = 2'd3
    } outcome_e;

    // Configuration register indexes (byte address 4*index)
    typedef enum logic [1:0] {
        REG_HSPR      = 2'd0,
        REG_KEEP      = 2'd1,
        REG_HOME      = 2'd2,
        REG_FIRST_POS = 2'd3
    } reg_idx_e;

    typedef struct packed {
        logic [HSPR_W-1:0] half_steps_per_rev;
        logic [CODE_W-1:0] keep_code;
        logic [CODE_W-1:0] home_code;
        logic [CODE_W-1:0] first_position_code;
    } cfg_t;

    typedef struct packed {
        logic referenced;
        logic moving;
        logic homing;
        logic released;
        logic persist;
    } flags_t;

    typedef struct packed {
        cmd_e                cmd;
        logic [CODE_W-1:0]   command_byte;
        logic [STORED_W-1:0] restore_pos;
        logic                stored_valid;
        logic                home_sensor;
    } cmd_item_t;

    typedef struct packed {
        outcome_e          command_outcome;
        logic              arrived;
        logic [7:0]        status_byte;
        logic [HSPR_W-1:0] steps_to_next;
        logic              moving_now;
        logic              homing_now;
        logic              persist_needed;
    } rsp_item_t;

endpackage
`default_nettype wire

[hw/rtl/iwpc_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwpc_regs
// APB configuration registers: half steps per revolution and the three host
// command codes. Zero wait states; reads return the register value.
// ----------------------------------------------------------------------------
module iwpc_regs
    import iwpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    reg_idx_e idx;
    logic     wr_en;

    assign idx    = reg_idx_e'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_steps_per_rev  <= HSPR_RESET;
            cfg_reg.keep_code           <= KEEP_RESET;
            cfg_reg.home_code           <= HOME_RESET;
            cfg_reg.first_position_code <= FIRST_POS_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_HSPR:      cfg_reg.half_steps_per_rev  <= pwdata[HSPR_W-1:0];
                REG_KEEP:      cfg_reg.keep_code           <= pwdata[CODE_W-1:0];
                REG_HOME:      cfg_reg.home_code           <= pwdata[CODE_W-1:0];
                REG_FIRST_POS: cfg_reg.first_position_code <= pwdata[CODE_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_HSPR:      prdata = APB_DATA_W'(cfg_reg.half_steps_per_rev);
            REG_KEEP:      prdata = APB_DATA_W'(cfg_reg.keep_code);
            REG_HOME:      prdata = APB_DATA_W'(cfg_reg.home_code);
            REG_FIRST_POS: prdata = APB_DATA_W'(cfg_reg.first_position_code);
            default:       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/iwpc_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iwpc_step
// Next-state and result logic for one event: position, target and mode flags
// after the event, plus the outcome, status byte and half steps to next.
// ----------------------------------------------------------------------------
module iwpc_step
    import iwpc_pkg::*;
#(
    parameter int POSITION_BITS = 6
)
(
    input  wire cmd_item_t           item,
    input  wire cfg_t                cfg,
    input  wire logic [POSITION_BITS-1:0] pos,
    input  wire logic [POSITION_BITS-1:0] tgt,
    input  wire flags_t              flags,
    output logic [POSITION_BITS-1:0] pos_next,
    output logic [POSITION_BITS-1:0] tgt_next,
    output flags_t                   flags_next,
    output rsp_item_t                rsp
);

    localparam int PB = POSITION_BITS;
    localparam logic [CODE_W:0] POS_COUNT = (CODE_W+1)'(1 << PB);

    logic [POS_BITS_MAX-1:0] stored_ext;
    logic [CODE_W:0]         code_off;
    logic                    code_in_range;
    logic [PB-1:0]           code_pos;
    logic [PB-1:0]           pos_inc_wrap;
    logic                    ready;
    logic [PB-1:0]           rem;
    logic [PB:0]             pos_inc;
    logic [2*PB-1:0]         cur_prod;
    logic [2*PB:0]           nxt_prod;
    logic [HSPR_W-1:0]       base;
    outcome_e                outcome;
    logic                    arrived;

    // Decode host position codes
    assign stored_ext    = {1'b0, item.restore_pos};
    assign code_off      = {1'b0, item.command_byte} - {1'b0, cfg.first_position_code};
    assign code_in_range = !code_off[CODE_W] && (code_off < POS_COUNT);
    assign code_pos      = code_off[PB-1:0];
    assign pos_inc_wrap  = pos + PB'(1);

    // Apply the event
    always_comb
    begin
        pos_next   = pos;
        tgt_next   = tgt;
        flags_next = flags;
        outcome    = OUT_IGNORED;
        arrived    = 1'b0;
        case (item.cmd)
            CMD_LOAD:
            begin
                pos_next   = stored_ext[PB-1:0];
                tgt_next   = stored_ext[PB-1:0];
                flags_next = '0;
                flags_next.referenced = item.stored_valid;
            end
            CMD_HOST:
            begin
                if (item.command_byte == cfg.keep_code)
                begin
                    outcome = OUT_ACCEPTED;
                end
                else if (item.command_byte == cfg.home_code)
                begin
                    if (!flags.moving)
                    begin
                        flags_next        = '0;
                        flags_next.moving = 1'b1;
                        flags_next.homing = 1'b1;
                        outcome           = OUT_START_HOME;
                    end
                end
                else if (code_in_range && flags.referenced)
                begin
                    tgt_next = code_pos;
                    if (flags.moving || code_pos == pos)
                    begin
                        outcome = OUT_ACCEPTED;
                    end
                    else
                    begin
                        flags_next.moving  = 1'b1;
                        flags_next.persist = 1'b1;
                        outcome            = OUT_START_MOVE;
                    end
                end
            end
            CMD_STEP:
            begin
                pos_next = pos_inc_wrap;
                if (pos_inc_wrap == tgt)
                begin
                    flags_next.moving = 1'b0;
                    arrived           = 1'b1;
                end
            end
            CMD_SENSOR:
            begin
                if (flags.homing)
                begin
                    if (!item.home_sensor)
                    begin
                        flags_next.released = 1'b1;
                    end
                    else if (flags.released)
                    begin
                        pos_next   = '0;
                        tgt_next   = '0;
                        flags_next = '0;
                        flags_next.referenced = 1'b1;
                        flags_next.persist    = 1'b1;
                        arrived    = 1'b1;
                    end
                end
            end
            CMD_HOME_FAIL:
            begin
                if (flags.homing)
                begin
                    tgt_next   = pos;
                    flags_next = '0;
                end
            end
            CMD_PERSISTED:
            begin
                if (!flags.moving)
                begin
                    flags_next.persist = 1'b0;
                end
            end
            default:
            begin
                pos_next = pos;
            end
        endcase
    end

    // Half steps to next position: even share plus spread of the remainder
    assign rem      = cfg.half_steps_per_rev[PB-1:0];
    assign base     = cfg.half_steps_per_rev >> PB;
    assign pos_inc  = {1'b0, pos_next} + (PB+1)'(1);
    assign cur_prod = {{PB{1'b0}}, rem} * {{PB{1'b0}}, pos_next};
    assign nxt_prod = {{(PB+1){1'b0}}, rem} * {{PB{1'b0}}, pos_inc};

    assign ready = flags_next.referenced && !flags_next.moving && !flags_next.persist;

    // Assemble the result beat
    always_comb
    begin
        rsp.command_outcome = outcome;
        rsp.arrived         = arrived;
        rsp.status_byte     = {1'b1, ready, 6'b0} | 8'(pos_next);
        rsp.steps_to_next   = base + HSPR_W'(nxt_prod[2*PB:PB])
                              - HSPR_W'(cur_prod[2*PB-1:PB]);
        rsp.moving_now      = flags_next.moving;
        rsp.homing_now      = flags_next.homing;
        rsp.persist_needed  = flags_next.persist;
    end

endmodule
`default_nettype wire

[hw/rtl/indexed_wheel_position_controller_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_wheel_position_controller_core
// Wheel position controller: keeps position, target and mode flags, handles
// one event beat per cycle unless rsp stalls, and returns one result beat per event.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Beat
//  ---------+-----------+----------------------+------------------------------
//  cmd      | in        | cmd_valid/cmd_stall  | cmd_item_t: one event
//  rsp      | out       | rsp_valid/rsp_stall  | rsp_item_t: one result
//  apb      | in        | psel/penable/pready  | configuration registers
//
// One event per cycle sustained unless rsp stalls; beats pass the input register,
// then the result register. The state update through iwpc_step is combinational.
// Reset clears position, target and flags and loads register defaults.
// A stalled result holds; the input register keeps taking beats until both
// it and the result register are full.
// ----------------------------------------------------------------------------
module indexed_wheel_position_controller_core
    import iwpc_pkg::*;
#(
    parameter int POSITION_BITS = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_stall,
    input  wire cmd_item_t             cmd_data,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsp_item_t                  rsp_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t                     cfg;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    cmd_item_t                s1_data_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_item_t                rsp_data_reg;
    logic                     cmd_accept;
    logic                     rsp_load;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] tgt_reg;
    logic [POSITION_BITS-1:0] tgt_next;
    flags_t                   flags_reg;
    flags_t                   flags_next;
    rsp_item_t                rsp_calc;

    iwpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    iwpc_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .item       (s1_data_reg),
        .cfg        (cfg),
        .pos        (pos_reg),
        .tgt        (tgt_reg),
        .flags      (flags_reg),
        .pos_next   (pos_next),
        .tgt_next   (tgt_next),
        .flags_next (flags_next),
        .rsp        (rsp_calc)
    );

    // Flow control: advance the input beat when the result slot frees up
    assign rsp_load       = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall      = s1_valid_reg && !rsp_load;
    assign cmd_accept     = cmd_valid && !cmd_stall;
    assign s1_valid_next  = cmd_accept || (s1_valid_reg && !rsp_load);
    assign rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Hold control state and wheel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            pos_reg       <= '0;
            tgt_reg       <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (rsp_load)
            begin
                pos_reg   <= pos_next;
                tgt_reg   <= tgt_next;
                flags_reg <= flags_next;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_data_reg <= cmd_data;
        end
        if (rsp_load)
        begin
            rsp_data_reg <= rsp_calc;
        end
    end

    // A waiting input beat must not be overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !rsp_load |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("input register lost a waiting beat");

    // Release is only tracked during homing
    a_released_homing: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.released |-> flags_reg.homing)
        else $error("released flag set outside homing");

    // Arrival never comes from a host command
    a_arrived_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_data_reg.arrived |->
            rsp_data_reg.command_outcome == OUT_IGNORED)
        else $error("arrival reported with a host command outcome");

    // Each loaded result reflects the state written with it
    a_rsp_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> rsp_data_reg.moving_now == flags_reg.moving
                     && rsp_data_reg.homing_now == flags_reg.homing
                     && rsp_data_reg.persist_needed == flags_reg.persist)
        else $error("result flags differ from stored flags");

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wheel position controller. A directed table is
// walked first, then phases of random event sequences (homing, moves to
// a position, noise) run under several register settings. Each phase uses one
// of four sender and receiver idle patterns. Every result beat is compared field
// by field with a local model of the wheel state.
// ----------------------------------------------------------------------------
module tb_top;
    import iwpc_pkg::*;

    localparam int POS_BITS        = 6;
    localparam int POS_COUNT       = 1 << POS_BITS;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int HOLD_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 100;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct {
        cmd_item_t ev;
        bit        has_lit;
        rsp_item_t rsp;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_stall;
    cmd_item_t             cmd_data;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_item_t             rsp_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Wheel model state and its copy of the registers
    logic [POS_BITS-1:0] whl_pos;
    logic [POS_BITS-1:0] whl_tgt;
    flags_t              whl_flg;
    cfg_t                cfg;

    rsp_item_t pending_results[$];
    dir_row_t  dir_tab[$];
    int        err_count;
    int        items_sent;
    int        cycles;
    int        send_idle_pct;
    int        stall_pct;
    int        hold_req;

    indexed_wheel_position_controller_core #(
        .POSITION_BITS(POS_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Run the clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Half steps from position p to the next one, spreading the remainder
    function automatic logic [15:0] half_steps_to_next(logic [POS_BITS-1:0] p);
        int unsigned rev;
        int unsigned base;
        int unsigned rem;
        int unsigned cur;
        int unsigned nxt;
        rev  = cfg.half_steps_per_rev;
        base = rev / POS_COUNT;
        rem  = rev % POS_COUNT;
        cur  = rem * 32'(p) / POS_COUNT;
        nxt  = rem * (32'(p) + 1) / POS_COUNT;
        return 16'(base + nxt - cur);
    endfunction

    // Decode a host byte: keep first, then home, then the position range
    function automatic outcome_e host_byte(logic [7:0] b);
        int d;
        d = int'(b) - int'(cfg.first_position_code);
        if (b == cfg.keep_code)
            return OUT_ACCEPTED;
        if (b == cfg.home_code)
        begin
            if (whl_flg.moving)
                return OUT_IGNORED;
            whl_flg        = '0;
            whl_flg.moving = 1'b1;
            whl_flg.homing = 1'b1;
            return OUT_START_HOME;
        end
        if (d < 0 || d >= POS_COUNT || !whl_flg.referenced)
            return OUT_IGNORED;
        whl_tgt = d[POS_BITS-1:0];
        if (whl_flg.moving || whl_tgt == whl_pos)
            return OUT_ACCEPTED;
        whl_flg.moving  = 1'b1;
        whl_flg.persist = 1'b1;
        return OUT_START_MOVE;
    endfunction

    // Apply one event to the wheel state and form its result
    function automatic rsp_item_t wheel_event(cmd_item_t ev);
        rsp_item_t r;
        logic      ready;
        r                 = '0;
        r.command_outcome = OUT_IGNORED;
        case (ev.cmd)
            CMD_LOAD:
            begin
                whl_pos            = ev.restore_pos;
                whl_tgt            = ev.restore_pos;
                whl_flg            = '0;
                whl_flg.referenced = ev.stored_valid;
            end
            CMD_HOST:
                r.command_outcome = host_byte(ev.command_byte);
            CMD_STEP:
            begin
                whl_pos = whl_pos + POS_BITS'(1);
                if (whl_pos == whl_tgt)
                begin
                    whl_flg.moving = 1'b0;
                    r.arrived      = 1'b1;
                end
            end
            CMD_SENSOR:
            begin
                if (whl_flg.homing)
                begin
                    if (!ev.home_sensor)
                        whl_flg.released = 1'b1;
                    else if (whl_flg.released)
                    begin
                        whl_pos            = '0;
                        whl_tgt            = '0;
                        whl_flg            = '0;
                        whl_flg.referenced = 1'b1;
                        whl_flg.persist    = 1'b1;
                        r.arrived          = 1'b1;
                    end
                end
            end
            CMD_HOME_FAIL:
            begin
                if (whl_flg.homing)
                begin
                    whl_tgt = whl_pos;
                    whl_flg = '0;
                end
            end
            CMD_PERSISTED:
            begin
                if (!whl_flg.moving)
                    whl_flg.persist = 1'b0;
            end
            default:
            begin
            end
        endcase
        ready            = whl_flg.referenced && !whl_flg.moving && !whl_flg.persist;
        r.status_byte    = {1'b1, ready, whl_pos};
        r.steps_to_next  = half_steps_to_next(whl_pos);
        r.moving_now     = whl_flg.moving;
        r.homing_now     = whl_flg.homing;
        r.persist_needed = whl_flg.persist;
        return r;
    endfunction

    function automatic cmd_item_t mk_cmd(logic [2:0] code, logic [7:0] b,
                                         logic [5:0] stored, logic sv, logic sensor);
        cmd_item_t ev;
        ev.cmd          = cmd_e'(code);
        ev.command_byte = b;
        ev.restore_pos  = stored;
        ev.stored_valid = sv;
        ev.home_sensor  = sensor;
        return ev;
    endfunction

    function automatic rsp_item_t mk_rsp(outcome_e o, logic arr, logic [7:0] st,
                                         logic [15:0] sn, logic mv, logic hm, logic ps);
        rsp_item_t r;
        r.command_outcome = o;
        r.arrived         = arr;
        r.status_byte     = st;
        r.steps_to_next   = sn;
        r.moving_now      = mv;
        r.homing_now      = hm;
        r.persist_needed  = ps;
        return r;
    endfunction

    // Event of the given code with every other field random
    function automatic cmd_item_t rand_event(logic [2:0] code);
        return mk_cmd(code, 8'($urandom_range(255)), 6'($urandom_range(63)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    function automatic logic [2:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 10) return CMD_LOAD;
        if (r < 40) return CMD_HOST;
        if (r < 60) return CMD_STEP;
        if (r < 78) return CMD_SENSOR;
        if (r < 83) return CMD_HOME_FAIL;
        if (r < 93) return CMD_PERSISTED;
        if (r < 97) return CMD_QUERY;
        return CMD_UNUSED;
    endfunction

    // Host bytes lean toward the programmed codes and the position range, running a little past its top
    function automatic logic [7:0] pick_host_byte();
        int r;
        r = $urandom_range(99);
        if (r < 20) return cfg.keep_code;
        if (r < 40) return cfg.home_code;
        if (r < 85) return cfg.first_position_code + 8'($urandom_range(70));
        return 8'($urandom_range(255));
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        // Keep the log bounded when the block is badly broken
        if (err_count < MAX_REPORTS)
            $display("MISMATCH %s: got 0x%0h expected 0x%0h (cycle %0d)",
                     what, got, want, cycles);
        err_count++;
    endtask

    // Offer one beat after a random idle gap, predict it once accepted
    task automatic send_cmd(input cmd_item_t ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd_data  = ev;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        pending_results.push_back(wheel_event(ev));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_code(input logic [2:0] code);
        cmd_item_t ev;
        ev = rand_event(code);
        if (code == CMD_HOST)
            ev.command_byte = pick_host_byte();
        send_cmd(ev);
    endtask

    task automatic send_host(input logic [7:0] b);
        cmd_item_t ev;
        ev              = rand_event(CMD_HOST);
        ev.command_byte = b;
        send_cmd(ev);
    endtask

    task automatic send_sensor(input logic level);
        cmd_item_t ev;
        ev             = rand_event(CMD_SENSOR);
        ev.home_sensor = level;
        send_cmd(ev);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_HSPR:      cfg.half_steps_per_rev  = val[15:0];
            REG_KEEP:      cfg.keep_code           = val[7:0];
            REG_HOME:      cfg.home_code           = val[7:0];
            REG_FIRST_POS: cfg.first_position_code = val[7:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain outstanding results, let the pipe settle, then program all registers
    task automatic apply_config(input logic [15:0] hspr, input logic [7:0] keep,
                                input logic [7:0] home, input logic [7:0] first);
        cmd_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write(REG_HSPR, {16'd0, hspr});
        cfg_write(REG_KEEP, {24'd0, keep});
        cfg_write(REG_HOME, {24'd0, home});
        cfg_write(REG_FIRST_POS, {24'd0, first});
    endtask

    // One random sequence: a homing run, a move to a position, or noise
    task automatic run_sequence();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            send_host(cfg.home_code);
            repeat ($urandom_range(3)) send_code(CMD_SENSOR);
            if ($urandom_range(9) == 0)
                send_code(CMD_HOME_FAIL);
            else
            begin
                send_sensor(1'b0);
                repeat ($urandom_range(2)) send_sensor(1'b0);
                send_sensor(1'b1);
                if ($urandom_range(1) == 0)
                    send_code(CMD_PERSISTED);
            end
        end
        else if (kind < 70)
        begin
            if (!whl_flg.referenced)
            begin
                cmd_item_t ev;
                ev              = rand_event(CMD_LOAD);
                ev.stored_valid = 1'b1;
                send_cmd(ev);
            end
            send_host(cfg.first_position_code + 8'($urandom_range(63)));
            // Step until the target is reached, or a few stray steps if idle
            if (whl_flg.moving)
            begin
                n = int'(6'(whl_tgt - whl_pos));
                if (n == 0)
                    n = POS_COUNT;
            end
            else
                n = $urandom_range(2);
            repeat (n) send_code(CMD_STEP);
            if ($urandom_range(9) < 7)
                send_code(CMD_PERSISTED);
        end
        else
            repeat ($urandom_range(1, 4)) send_code(pick_code());
    endtask

    task automatic build_directed();
        rsp_item_t idle_rsp;
        idle_rsp = mk_rsp(OUT_IGNORED, 1'b0, 8'h80, 16'd64, 1'b0, 1'b0, 1'b0);
        // After reset: nothing referenced, every step count is 4096/64
        dir_tab.push_back('{mk_cmd(CMD_QUERY, 8'h00, 6'd0, 1'b0, 1'b0), 1'b1, idle_rsp});
        dir_tab.push_back('{mk_cmd(CMD_UNUSED, 8'h00, 6'd0, 1'b0, 1'b0), 1'b1, idle_rsp});
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd64, 6'd0, 1'b0, 1'b0), 1'b1, idle_rsp});
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd0, 6'd0, 1'b0, 1'b0), 1'b1,
                           mk_rsp(OUT_ACCEPTED, 1'b0, 8'h80, 16'd64, 1'b0, 1'b0, 1'b0)});
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'hFF, 6'd0, 1'b0, 1'b0), 1'b1, idle_rsp});
        dir_tab.push_back('{mk_cmd(CMD_LOAD, 8'h00, 6'd63, 1'b1, 1'b0), 1'b1,
                           mk_rsp(OUT_IGNORED, 1'b0, 8'hFF, 16'd64, 1'b0, 1'b0, 1'b0)});
        dir_tab.push_back('{mk_cmd(CMD_LOAD, 8'h00, 6'd0, 1'b0, 1'b0), 1'b1, idle_rsp});
        // Moves: same position, start, out of range, retarget while moving, step to arrival
        dir_tab.push_back('{mk_cmd(CMD_LOAD, 8'h00, 6'd5, 1'b1, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd69, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd127, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd128, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd70, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_PERSISTED, 8'h00, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_STEP, 8'h00, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_PERSISTED, 8'h00, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        // Sensor and home-fail events outside homing have no effect; a step still advances the position
        dir_tab.push_back('{mk_cmd(CMD_STEP, 8'h00, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_SENSOR, 8'h00, 6'd0, 1'b0, 1'b1), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_HOME_FAIL, 8'h00, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        // Homing: start, repeat while moving, release, complete
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd1, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd1, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_SENSOR, 8'h00, 6'd0, 1'b0, 1'b1), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_SENSOR, 8'h00, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_SENSOR, 8'h00, 6'd0, 1'b0, 1'b1), 1'b0, '0});
        // Homing abandoned, then all input bits high
        dir_tab.push_back('{mk_cmd(CMD_HOST, 8'd1, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_HOME_FAIL, 8'h00, 6'd0, 1'b0, 1'b0), 1'b0, '0});
        dir_tab.push_back('{mk_cmd(CMD_QUERY, 8'hFF, 6'd63, 1'b1, 1'b1), 1'b1,
                           mk_rsp(OUT_IGNORED, 1'b0, 8'h80, 16'd64, 1'b0, 1'b0, 1'b0)});
    endtask

    // Receiver: random stall, or a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall = 1'b1;
            end
            else
                rsp_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", 32'(rsp_data), '0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_data.command_outcome !== want.command_outcome)
                    report_mismatch("command_outcome", 32'(rsp_data.command_outcome),
                                    32'(want.command_outcome));
                if (rsp_data.arrived !== want.arrived)
                    report_mismatch("arrived", 32'(rsp_data.arrived), 32'(want.arrived));
                if (rsp_data.status_byte !== want.status_byte)
                    report_mismatch("status_byte", 32'(rsp_data.status_byte),
                                    32'(want.status_byte));
                if (rsp_data.steps_to_next !== want.steps_to_next)
                    report_mismatch("steps_to_next", 32'(rsp_data.steps_to_next),
                                    32'(want.steps_to_next));
                if (rsp_data.moving_now !== want.moving_now)
                    report_mismatch("moving_now", 32'(rsp_data.moving_now),
                                    32'(want.moving_now));
                if (rsp_data.homing_now !== want.homing_now)
                    report_mismatch("homing_now", 32'(rsp_data.homing_now),
                                    32'(want.homing_now));
                if (rsp_data.persist_needed !== want.persist_needed)
                    report_mismatch("persist_needed", 32'(rsp_data.persist_needed),
                                    32'(want.persist_needed));
            end
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("indexed_wheel_position_controller_core verification failed");
        $finish;
    end

    // Main stimulus
    initial
    begin
        logic [15:0] hspr;
        logic [7:0]  keep;
        logic [7:0]  home;
        logic [7:0]  first;
        int          phase_end;

        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd_data      = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        err_count     = 0;
        items_sent    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 0;
        whl_pos       = '0;
        whl_tgt       = '0;
        whl_flg       = '0;
        cfg.half_steps_per_rev  = HSPR_RESET;
        cfg.keep_code           = KEEP_RESET;
        cfg.home_code           = HOME_RESET;
        cfg.first_position_code = FIRST_POS_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table; typed-in rows override the prediction
        build_directed();
        foreach (dir_tab[i])
        begin
            send_cmd(dir_tab[i].ev);
            if (dir_tab[i].has_lit)
            begin
                void'(pending_results.pop_back());
                pending_results.push_back(dir_tab[i].rsp);
            end
        end

        // Random phases, each with its own settings and one of four idle patterns
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    hspr = 16'd4096; keep = 8'd0; home = 8'd1; first = 8'd64;
                end
                1:
                begin
                    hspr = 16'd0; keep = 8'd0; home = 8'd1; first = 8'd0;
                end
                2:
                begin
                    // keep and home collide, top position code at 255
                    hspr = 16'hFFFF; keep = 8'hFF; home = 8'hFF; first = 8'd192;
                end
                3:
                begin
                    // only position zero has a code
                    hspr = 16'd63; keep = 8'd10; home = 8'd20; first = 8'hFF;
                end
                4:
                begin
                    // home code inside the position range
                    hspr = 16'd100; keep = 8'd3; home = 8'd70; first = 8'd64;
                end
                5:
                begin
                    hspr  = 16'($urandom_range(65535));
                    keep  = 8'($urandom_range(255));
                    home  = 8'($urandom_range(255));
                    first = 8'($urandom_range(255));
                end
                6:
                begin
                    hspr  = 16'd4097;
                    keep  = 8'($urandom_range(255));
                    home  = 8'($urandom_range(255));
                    first = 8'd200;
                end
                default:
                begin
                    hspr  = 16'($urandom_range(65535));
                    keep  = 8'($urandom_range(255));
                    home  = 8'($urandom_range(255));
                    first = 8'($urandom_range(255));
                end
            endcase
            apply_config(hspr, keep, home, first);

            case (ph % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 86; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            // Long receiver hold-off while the sender keeps offering beats
            if (ph == 0 || ph == NUM_PHASES - 1)
                hold_req++;

            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
                run_sequence();
        end

        // Drop valid, drain, then allow the pipe latency to pass
        cmd_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (err_count == 0)
            $display("indexed_wheel_position_controller_core verification clean");
        else
            $display("indexed_wheel_position_controller_core verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/iwpc_pkg.sv
hw/rtl/iwpc_regs.sv
hw/rtl/iwpc_step.sv
hw/rtl/indexed_wheel_position_controller_core.sv
dv/tb_top.sv
